[design/irdps_pkg.sv]
// ----------------------------------------------------------------------------
// irdps_pkg: shared types and constants of the IR distance search unit
// Calibration coefficients in Q15.48, register index and the command/status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package irdps_pkg;

	localparam int FRAC_BITS = 48;
	localparam int DATA_W    = 64;
	localparam int K_W       = 8;
	localparam int READING_W = 10;
	localparam int WINDOW_W  = 8;
	localparam int NUM_COEF  = 6;

	// configuration register select (address bit 2)
	localparam logic REG_MATCH_WINDOW = 1'b0;
	localparam logic [WINDOW_W-1:0] MATCH_WINDOW_RESET = 8'd10;

	// coefficient magnitudes c_i / 10^i, rounded to nearest Q48
	localparam logic [63:0] MAG6 = ((64'd22738 / 64'd6103515625) << 34)
		+ ((((64'd22738 % 64'd6103515625) << 34) + 64'd6103515625 / 64'd2)
		/ 64'd6103515625);
	localparam logic [63:0] MAG5 = ((64'd169745 / 64'd244140625) << 36)
		+ ((((64'd169745 % 64'd244140625) << 36) + 64'd244140625 / 64'd2)
		/ 64'd244140625);
	localparam logic [63:0] MAG4 = ((64'd470274283 / 64'd1220703125) << 35)
		+ ((((64'd470274283 % 64'd1220703125) << 35) + 64'd1220703125 / 64'd2)
		/ 64'd1220703125);
	localparam logic [63:0] MAG3 = ((64'd1168012123 / 64'd48828125) << 36)
		+ ((((64'd1168012123 % 64'd48828125) << 36) + 64'd48828125 / 64'd2)
		/ 64'd48828125);
	localparam logic [63:0] MAG2 = ((64'd31350111 / 64'd390625) << 40)
		+ ((((64'd31350111 % 64'd390625) << 40) + 64'd390625 / 64'd2)
		/ 64'd390625);
	localparam logic [63:0] MAG1 = ((64'd97704 / 64'd625) << 44)
		+ ((((64'd97704 % 64'd625) << 44) + 64'd625 / 64'd2) / 64'd625);
	localparam logic [63:0] MAG0 = ((64'd716594 / 64'd125) << 45)
		+ ((((64'd716594 % 64'd125) << 45) + 64'd125 / 64'd2) / 64'd125);

	// leading Horner coefficient, then the signed addends of each step
	localparam logic [63:0] HORNER_LEAD = MAG6;
	localparam logic [63:0] HORNER_ADD [NUM_COEF] = '{
		(~MAG5) + 64'd1,
		MAG4,
		(~MAG3) + 64'd1,
		MAG2,
		(~MAG1) + 64'd1,
		MAG0
	};

	typedef struct packed {
		logic           start;
		logic           issue;
		logic           last;
		logic [K_W-1:0] k;
		logic           load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic last_done;
	} dp_status_t;

endpackage

[design/irdps_ctrl.sv]
// ----------------------------------------------------------------------------
// irdps_ctrl: sequencer of the IR distance search
// Accepts an item, issues one distance step per cycle into the datapath,
// waits for the pipeline to drain and hands the result to the output register.
// ----------------------------------------------------------------------------
module irdps_ctrl #(
	parameter int NUM_STEPS = 230
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	output logic                  out_valid,
	input  logic                  out_stall,
	input  irdps_pkg::dp_status_t status,
	output irdps_pkg::ctrl_cmd_t  cmd
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_RUN    = 4'b0010,
		ST_DRAIN  = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	localparam logic [irdps_pkg::K_W-1:0] LAST_K = irdps_pkg::K_W'(NUM_STEPS - 1);

	state_t                      state_q;
	logic [irdps_pkg::K_W-1:0]   k_q;
	logic                        out_valid_q;
	logic                        accept;
	logic                        load_out;
	logic                        last_k;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign last_k    = (k_q == LAST_K);
	assign load_out  = (state_q == ST_FINISH) && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.start    = accept;
		cmd.issue    = (state_q == ST_RUN);
		cmd.last     = last_k;
		cmd.k        = k_q;
		cmd.load_out = load_out;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RUN;
						k_q     <= '0;
					end
				end
				ST_RUN: begin
					k_q <= k_q + 1'b1;
					if (last_k)
						state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (status.last_done)
						state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (load_out)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// hold the result until the consumer takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	a_last_while_drain: assert property (@(posedge clk) disable iff (!arst_n)
		status.last_done |-> state_q == ST_DRAIN)
		else $error("last step returned outside drain");

	a_start_run: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_RUN) && (k_q == '0))
		else $error("accepted item did not start at step zero");

	a_run_to_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) && last_k |=> state_q == ST_DRAIN)
		else $error("issue did not stop after last step");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> out_valid_q)
		else $error("loaded result not presented");

endmodule

[design/irdps_dp.sv]
// ----------------------------------------------------------------------------
// irdps_dp: Horner pipeline and window match of the IR distance search
// Six multiply/add step pairs evaluate the calibration polynomial for one
// distance step per cycle; a compare stage tracks the last step in the window.
// ----------------------------------------------------------------------------
module irdps_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  irdps_pkg::ctrl_cmd_t                cmd,
	output irdps_pkg::dp_status_t               status,
	input  logic [irdps_pkg::READING_W-1:0]     reading,
	input  logic [irdps_pkg::WINDOW_W-1:0]      match_window,
	output logic [irdps_pkg::K_W-1:0]           distance_tenths,
	output logic                                match_found
);

	localparam int NC    = irdps_pkg::NUM_COEF;
	localparam int LAST  = 2 * NC + 1;
	localparam int BND_W = irdps_pkg::READING_W + 2;

	logic                              vld_s  [0:LAST];
	logic                              last_s [0:LAST];
	logic [irdps_pkg::K_W-1:0]         k_s    [0:LAST];
	logic [irdps_pkg::DATA_W-1:0]      acc_s  [1:2*NC];
	logic                              match_s13;

	logic signed [irdps_pkg::DATA_W-1:0] lo_q;
	logic signed [irdps_pkg::DATA_W-1:0] hi_q;
	logic                                found_q;
	logic [irdps_pkg::K_W-1:0]           dist_q;
	logic                                found_out_q;
	logic [irdps_pkg::K_W-1:0]           dist_out_q;

	logic signed [BND_W-1:0] diff;
	logic signed [BND_W-1:0] sum;

	assign diff = $signed({2'b00, reading}) - $signed({4'b0000, match_window});
	assign sum  = $signed({2'b00, reading}) + $signed({4'b0000, match_window});

	// window bounds in Q48, captured when the item is accepted
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			lo_q <= {{(irdps_pkg::DATA_W - irdps_pkg::FRAC_BITS - BND_W){diff[BND_W-1]}},
				diff, {irdps_pkg::FRAC_BITS{1'b0}}};
			hi_q <= {{(irdps_pkg::DATA_W - irdps_pkg::FRAC_BITS - BND_W){sum[BND_W-1]}},
				sum, {irdps_pkg::FRAC_BITS{1'b0}}};
		end
	end

	// control tags that travel with each step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= LAST; i++)
				vld_s[i] <= 1'b0;
		end else begin
			vld_s[0] <= cmd.issue;
			for (int i = 1; i <= LAST; i++)
				vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		k_s[0]    <= cmd.k;
		last_s[0] <= cmd.last;
		for (int i = 1; i <= LAST; i++) begin
			k_s[i]    <= k_s[i-1];
			last_s[i] <= last_s[i-1];
		end
	end

	for (genvar j = 0; j < NC; j++) begin : g_horner
		logic [irdps_pkg::DATA_W-1:0]             src;
		logic [irdps_pkg::DATA_W+irdps_pkg::K_W-1:0] full;

		if (j == 0) begin : g_lead
			assign src = irdps_pkg::HORNER_LEAD;
		end else begin : g_chain
			assign src = acc_s[2*j];
		end

		// products wrap modulo 2^64
		assign full = src * k_s[2*j];

		always_ff @(posedge clk) begin
			acc_s[2*j+1] <= full[irdps_pkg::DATA_W-1:0];
			acc_s[2*j+2] <= acc_s[2*j+1] + irdps_pkg::HORNER_ADD[j];
		end
	end

	always_ff @(posedge clk) begin
		match_s13 <= ($signed(acc_s[2*NC]) > lo_q) && ($signed(acc_s[2*NC]) < hi_q);
	end

	// keep the last matching step of the current item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			dist_q  <= '0;
		end else if (cmd.start) begin
			found_q <= 1'b0;
			dist_q  <= '0;
		end else if (vld_s[LAST] && match_s13) begin
			found_q <= 1'b1;
			dist_q  <= k_s[LAST];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			found_out_q <= found_q;
			dist_out_q  <= dist_q;
		end
	end

	assign status.last_done = vld_s[LAST] && last_s[LAST];
	assign distance_tenths  = dist_out_q;
	assign match_found      = found_out_q;

	a_found_has_dist: assert property (@(posedge clk) disable iff (!arst_n)
		!found_q |-> dist_q == '0)
		else $error("distance set without a match");

endmodule

[design/ir_distance_inverse_poly_search_unit.sv]
// ----------------------------------------------------------------------------
// ir_distance_inverse_poly_search_unit: IR reading to distance by curve search
// Evaluates the degree-6 calibration curve at every distance step and returns
// the last step whose value lies strictly inside the window around the reading.
// ----------------------------------------------------------------------------
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------
//  in       | in_valid/in_stall  | reading[9:0]
//  out      | out_valid/out_stall| distance_tenths[7:0], match_found
//  config   | psel/penable/pready| paddr[2:0], pwdata/prdata[31:0]
//
//  One distance step is issued per cycle into the 13-stage Horner and
//  compare pipeline; after the last step the pipeline drains and the
//  result is handed to the output register.
//  An item is accepted only while the sequencer is idle; a finished result
//  waits in the output register and does not block the next accept.
//  Reset clears control state and sets match_window to 10.
//
module ir_distance_inverse_poly_search_unit #(
	parameter int NUM_STEPS = 230
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [9:0]  reading,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  distance_tenths,
	output logic        match_found,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	irdps_pkg::ctrl_cmd_t  cmd;
	irdps_pkg::dp_status_t status;
	logic [irdps_pkg::WINDOW_W-1:0] match_window_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == irdps_pkg::REG_MATCH_WINDOW)
		? {{(32 - irdps_pkg::WINDOW_W){1'b0}}, match_window_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_window_q <= irdps_pkg::MATCH_WINDOW_RESET;
		end else if (psel && penable && pwrite && pready
			&& (paddr[2] == irdps_pkg::REG_MATCH_WINDOW)) begin
			match_window_q <= pwdata[irdps_pkg::WINDOW_W-1:0];
		end
	end

	irdps_ctrl #(
		.NUM_STEPS (NUM_STEPS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	irdps_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.reading         (reading),
		.match_window    (match_window_q),
		.distance_tenths (distance_tenths),
		.match_found     (match_found)
	);

endmodule
